@@ hdl/srpg_pkg.sv @@
// ----------------------------------------------------------------------------
// srpg_pkg: shared types and constants of the stepper ramp profile generator
// Motion states, operation codes and register indexes.
// ----------------------------------------------------------------------------
package srpg_pkg;

    typedef enum logic [1:0] {
        MODE_STOP  = 2'd0,
        MODE_ACCEL = 2'd1,
        MODE_RUN   = 2'd2,
        MODE_DECEL = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_TARGET = 2'd1,
        OP_SETPOS = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_PLAN,
        FSM_STEP,
        FSM_DIV,
        FSM_FIN,
        FSM_OUT
    } fsm_t;

    localparam logic [1:0] REG_MIN_DELAY  = 2'd0;
    localparam logic [1:0] REG_INIT_DELAY = 2'd1;
    localparam logic [1:0] REG_THRESHOLD  = 2'd2;

    localparam logic [15:0] ONE_STEP_INTERVAL = 16'd1000;
    localparam int          DIV_W = 40;

endpackage

@@ hdl/stepper_ramp_profile_generator.sv @@
// ----------------------------------------------------------------------------
// stepper_ramp_profile_generator: linear acceleration ramp step generator
// Positions, plans and steps a motor; the ramp interval is updated by a
// bit-serial signed division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
// channel  dir  tdata (low bit up)                             tuser
// s_       in   operation[1:0], position_value[33:2], pad     -
// m_       out  step_pulse, direction, drive_enable,           -
//               position_now[34:3], motion_state[36:35],
//               step_interval[52:37], interval_saturated[53], pad
// cfg      in   cfg_wr_en, cfg_index, cfg_data[15:0]
//
// One item at a time. Non-step items pass IDLE, PLAN and OUT; steps at cruise
// add STEP and FIN. Ramp steps also run the 40-bit restoring divider (one bit
// per cycle) in DIV; the final decel step that replans a move repeats FIN.
// The result register holds until taken; s_tready is low meanwhile.
// Reset is synchronous, active low; all registers but op_reg, nd_reg and the divider take reset values.
// ----------------------------------------------------------------------------
module stepper_ramp_profile_generator
    import srpg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // operation, position_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // step_pulse, direction, drive_enable,
                                   // position_now, motion_state,
                                   // step_interval, interval_saturated
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    fsm_t  state_reg, state_next;

    logic [15:0] min_reg, init_reg;
    logic [7:0]  thr_reg;
    logic [31:0] pos_reg, tgt_reg, cnt_reg, rem_reg;
    logic        dirp_reg, en_reg;
    mode_t       mode_reg;
    logic [15:0] last_reg, cruise_reg, wait_reg;
    logic [1:0]  op_reg;
    logic        pulse_reg, sat_reg;
    logic        repl_reg;

    // divider
    logic [DIV_W-1:0] dvd_reg;    // |num| shifting out, quotient shifting in
    logic [DIV_W-1:0] prem_reg;   // partial remainder
    logic [DIV_W-1:0] dvs_reg;    // |div|
    logic             nneg_reg, dneg_reg;
    logic [5:0]       bit_reg;
    logic [15:0]      nd_reg;

    logic [DIV_W-1:0] trial;
    logic             fits;
    assign trial = {prem_reg[DIV_W-2:0], dvd_reg[DIV_W-1]};
    assign fits  = trial >= dvs_reg;

    // signed distance helpers
    logic [31:0] dist_c;
    logic        dneg_c;
    logic [32:0] ad_c;
    assign dist_c = tgt_reg - pos_reg;
    assign dneg_c = dist_c[31];
    assign ad_c   = dneg_c ? (33'd0 - {1'b1, dist_c}) : {1'b0, dist_c};

    logic [7:0]  thr_c;
    assign thr_c = (thr_reg == 8'd0) ? 8'd1 : thr_reg;

    logic [32:0] cnt_s;   // ramp_count sign-extended
    assign cnt_s = {cnt_reg[31], cnt_reg};
    logic ad_gt_cnt;
    assign ad_gt_cnt = $signed(ad_c) > $signed(cnt_s);

    logic step_c, repl_c;
    assign step_c = (op_reg == OP_TICK) && (mode_reg != MODE_STOP) && (wait_reg == 16'd0);
    assign repl_c = !repl_reg && (mode_reg == MODE_DECEL) && ($signed(cnt_reg) <= 0)
                    && (dist_c != 32'd0);

    assign s_tready = (state_reg == FSM_IDLE);
    assign m_tvalid = (state_reg == FSM_OUT);
    assign m_tdata  = {2'b00, sat_reg, last_reg, mode_reg, pos_reg, en_reg, dirp_reg,
                       pulse_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg  <= 16'd100;
            init_reg <= 16'd2000;
            thr_reg  <= 8'd8;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MIN_DELAY:  min_reg  <= cfg_data;
                REG_INIT_DELAY: init_reg <= cfg_data;
                REG_THRESHOLD:  thr_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE: if (s_tvalid) state_next = FSM_PLAN;
            FSM_PLAN: state_next = step_c ? FSM_STEP : FSM_OUT;
            FSM_STEP: state_next = (mode_reg == MODE_RUN) ? FSM_FIN : FSM_DIV;
            FSM_DIV:  if (bit_reg == 6'd0) state_next = FSM_FIN;
            FSM_FIN:  state_next = repl_c ? FSM_FIN : FSM_OUT;
            FSM_OUT:  if (m_tready) state_next = FSM_IDLE;
            default:  state_next = FSM_IDLE;
        endcase
    end

    // combined plan used by op 1/2 and replan
    logic [31:0] cnt_p, rem_p;
    logic        dirp_p, en_p;
    mode_t       mode_p;
    logic [15:0] last_p, wait_p;
    logic        started_p;
    always_comb begin
        cnt_p = cnt_reg; rem_p = rem_reg; dirp_p = dirp_reg; en_p = en_reg;
        mode_p = mode_reg; last_p = last_reg; wait_p = wait_reg; started_p = 1'b0;
        if (mode_reg == MODE_STOP) begin
            if (ad_c >= {25'd0, thr_c}) begin
                dirp_p = !dneg_c;
                wait_p = 16'd0;
                started_p = 1'b1;
                if (ad_c == 33'd1) begin
                    cnt_p = 32'd1;
                    mode_p = MODE_DECEL;
                    last_p = ONE_STEP_INTERVAL;
                end else begin
                    cnt_p = 32'd0;
                    rem_p = 32'd0;
                    en_p = 1'b1;
                    if (init_reg <= min_reg) begin
                        last_p = min_reg; mode_p = MODE_RUN;
                    end else begin
                        last_p = init_reg; mode_p = MODE_ACCEL;
                    end
                end
            end
        end else if (!dneg_c == dirp_reg) begin
            if (mode_reg == MODE_DECEL) begin
                if (ad_gt_cnt) mode_p = MODE_ACCEL;
            end else if (mode_reg == MODE_RUN) begin
                if (!ad_gt_cnt) begin
                    last_p = cruise_reg; mode_p = MODE_DECEL;
                end
            end else if (!ad_gt_cnt) begin
                mode_p = MODE_DECEL;
            end
        end else if (mode_reg == MODE_RUN || mode_reg == MODE_ACCEL) begin
            mode_p = MODE_DECEL;
        end
    end

    logic [DIV_W-1:0] num_c, div_c, q_s, r_s;
    logic [31:0]      cnt_n;
    logic signed [DIV_W-1:0] nd_s;
    logic [15:0]      nd_c;
    logic             sat_c;
    assign cnt_n = (mode_reg == MODE_ACCEL) ? cnt_reg + 32'd1 : cnt_reg - 32'd1;
    assign num_c = {{(DIV_W-17){1'b0}}, last_reg, 1'b0}
                 + {{(DIV_W-32){rem_reg[31]}}, rem_reg};
    assign div_c = (mode_reg == MODE_ACCEL)
                 ? {{(DIV_W-34){cnt_n[31]}}, cnt_n, 2'b01}
                 : ({{(DIV_W-34){1'b0}}, 34'd1} - {{(DIV_W-34){cnt_n[31]}}, cnt_n, 2'b00});
    assign q_s = (nneg_reg ^ dneg_reg) ? (~dvd_reg + 1'b1) : dvd_reg;
    assign r_s = nneg_reg ? (~prem_reg + 1'b1) : prem_reg;
    assign nd_s = $signed({{(DIV_W-16){1'b0}}, last_reg}) - $signed(q_s);
    assign sat_c = !nd_s[DIV_W-1] && (nd_s > $signed(DIV_W'(65535)));
    assign nd_c  = nd_s[DIV_W-1] ? 16'd0 : (sat_c ? 16'hFFFF : nd_s[15:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
            pos_reg <= '0; tgt_reg <= '0; dirp_reg <= 1'b1; mode_reg <= MODE_STOP;
            cnt_reg <= '0; last_reg <= '0; cruise_reg <= '0; rem_reg <= '0;
            wait_reg <= '0; en_reg <= 1'b0; pulse_reg <= 1'b0; sat_reg <= 1'b0;
            repl_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                FSM_IDLE: if (s_tvalid) begin
                    op_reg <= s_tdata[1:0];
                    pulse_reg <= 1'b0;
                    sat_reg <= 1'b0;
                    repl_reg <= 1'b0;
                    if (s_tdata[1:0] == OP_SETPOS) begin
                        pos_reg <= s_tdata[33:2];
                        tgt_reg <= s_tdata[33:2];
                    end else if (s_tdata[1:0] == OP_TARGET) begin
                        tgt_reg <= s_tdata[33:2];
                    end
                end
                FSM_PLAN: begin
                    if (op_reg == OP_TARGET || op_reg == OP_SETPOS) begin
                        cnt_reg <= cnt_p; rem_reg <= rem_p; dirp_reg <= dirp_p;
                        en_reg <= en_p; mode_reg <= mode_p; last_reg <= last_p;
                        wait_reg <= wait_p;
                    end else if (op_reg == OP_TICK && mode_reg != MODE_STOP) begin
                        if (wait_reg != 16'd0) begin
                            wait_reg <= wait_reg - 16'd1;
                        end else begin
                            pulse_reg <= 1'b1;
                            pos_reg <= dirp_reg ? pos_reg + 32'd1 : pos_reg - 32'd1;
                        end
                    end
                end
                FSM_STEP: begin
                    if (mode_reg != MODE_RUN) begin
                        cnt_reg  <= cnt_n;
                        nneg_reg <= num_c[DIV_W-1];
                        dneg_reg <= div_c[DIV_W-1];
                        dvd_reg  <= num_c[DIV_W-1] ? ~num_c + 1'b1 : num_c;
                        dvs_reg  <= div_c[DIV_W-1] ? ~div_c + 1'b1 : div_c;
                        prem_reg <= '0;
                        bit_reg  <= 6'(DIV_W - 1);
                    end
                end
                FSM_DIV: begin
                    prem_reg <= fits ? trial - dvs_reg : trial;
                    dvd_reg  <= {dvd_reg[DIV_W-2:0], fits};
                    bit_reg  <= bit_reg - 6'd1;
                end
                FSM_FIN: begin
                    if (repl_reg) begin
                        // replan after final decel step
                        repl_reg <= 1'b0;
                        cnt_reg <= cnt_p; rem_reg <= rem_p; dirp_reg <= dirp_p;
                        en_reg <= en_p; mode_reg <= mode_p;
                        if (started_p) begin
                            last_reg <= last_p;
                            wait_reg <= (last_p != 16'd0) ? last_p - 16'd1 : 16'd0;
                            sat_reg <= 1'b0;
                        end else begin
                            last_reg <= nd_reg;
                            wait_reg <= (nd_reg != 16'd0) ? nd_reg - 16'd1 : 16'd0;
                        end
                    end else if (mode_reg == MODE_RUN) begin
                        if (!ad_gt_cnt) begin
                            mode_reg <= MODE_DECEL;
                            last_reg <= cruise_reg;
                            wait_reg <= (cruise_reg != 16'd0) ? cruise_reg - 16'd1 : 16'd0;
                        end else begin
                            last_reg <= min_reg;
                            wait_reg <= (min_reg != 16'd0) ? min_reg - 16'd1 : 16'd0;
                        end
                    end else begin
                        sat_reg <= sat_c;
                        if (mode_reg == MODE_ACCEL && ad_gt_cnt && nd_c <= min_reg) begin
                            cruise_reg <= last_reg;
                            rem_reg    <= '0;
                            mode_reg   <= MODE_RUN;
                            last_reg   <= min_reg;
                            wait_reg   <= (min_reg != 16'd0) ? min_reg - 16'd1 : 16'd0;
                        end else begin
                            rem_reg  <= r_s[31:0];
                            last_reg <= nd_c;
                            wait_reg <= (nd_c != 16'd0) ? nd_c - 16'd1 : 16'd0;
                            if (mode_reg == MODE_ACCEL) begin
                                if (!ad_gt_cnt) mode_reg <= MODE_DECEL;
                            end else if ($signed(cnt_reg) <= 0) begin
                                mode_reg <= MODE_STOP;
                                nd_reg <= nd_c;
                                if (dist_c != 32'd0) repl_reg <= 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    logic unused_ok;
    assign unused_ok = ^{s_tdata[39:34]};

endmodule

@@ bench/tb_stepper_ramp_profile_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stepper_ramp_profile_generator: self-checking bench of the ramp generator
// Sends ticks, targets and position sets over the input stream, predicts each
// result beat with a behavioral ramp predictor and compares it field by field.
// ----------------------------------------------------------------------------
module tb_stepper_ramp_profile_generator;
    import srpg_pkg::*;

    typedef struct packed {
        logic        sat;
        logic [15:0] interval;
        logic [1:0]  mode;
        logic [31:0] pos;
        logic        enable;
        logic        dir;
        logic        pulse;
    } motion_rec_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    stepper_ramp_profile_generator uut (.*);

    always #5 aclk = ~aclk;

    // predictor state
    logic [15:0] p_min_delay, p_init_delay;
    logic [7:0]  p_threshold;
    logic [31:0] p_pos, p_target, p_count, p_rem;
    logic        p_dir, p_enabled;
    mode_t       p_mode;
    logic [15:0] p_interval, p_cruise, p_wait;

    motion_rec_t expected_q[$];
    int   errors = 0;
    int   idle_pct = 11;
    int   quiet_cycles = 0;
    bit   active = 0;

    task automatic report_mismatch(input string what, input longint got, input longint exp);
        errors++;
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
    endtask

    function automatic logic [15:0] clip16(input longint v, inout logic sat);
        if (v < 0) return 16'd0;
        if (v > 65535) begin
            sat = 1'b1;
            return 16'hFFFF;
        end
        return v[15:0];
    endfunction

    function automatic void plan_move(input logic [31:0] gap_bits);
        longint d, ad, cnt;
        logic [7:0] th;
        logic pos_dir;
        d = longint'($signed(gap_bits));
        pos_dir = d >= 0;
        ad = d < 0 ? -d : d;
        cnt = longint'($signed(p_count));
        if (p_mode == MODE_STOP) begin
            th = p_threshold == 8'd0 ? 8'd1 : p_threshold;
            if (ad >= th) begin
                p_dir = pos_dir;
                if (ad == 1) begin
                    p_count = 32'd1;
                    p_mode = MODE_DECEL;
                    p_interval = ONE_STEP_INTERVAL;
                end else begin
                    p_count = 32'd0;
                    p_rem = 32'd0;
                    if (p_init_delay <= p_min_delay) begin
                        p_interval = p_min_delay;
                        p_mode = MODE_RUN;
                    end else begin
                        p_interval = p_init_delay;
                        p_mode = MODE_ACCEL;
                    end
                    p_enabled = 1'b1;
                end
                p_wait = 16'd0;
            end
        end else if (pos_dir == p_dir) begin
            if (p_mode == MODE_DECEL) begin
                if (ad > cnt) p_mode = MODE_ACCEL;
            end else if (p_mode == MODE_RUN) begin
                if (ad <= cnt) begin
                    p_interval = p_cruise;
                    p_mode = MODE_DECEL;
                end
            end else if (ad <= cnt) p_mode = MODE_DECEL;
        end else if (p_mode == MODE_RUN || p_mode == MODE_ACCEL) p_mode = MODE_DECEL;
    endfunction

    function automatic logic take_step();
        logic sat, replanned;
        logic [15:0] nd;
        logic [31:0] gap_bits;
        longint d, ad, cnt, dv, num;
        sat = 1'b0;
        replanned = 1'b0;
        nd = 16'd0;
        p_pos = p_dir ? p_pos + 32'd1 : p_pos - 32'd1;
        gap_bits = p_target - p_pos;
        d = longint'($signed(gap_bits));
        ad = d < 0 ? -d : d;
        if (p_mode == MODE_ACCEL) begin
            cnt = longint'($signed(p_count)) + 1;
            p_count = cnt[31:0];
            dv = 4 * cnt + 1;
            num = 2 * longint'(p_interval) + longint'($signed(p_rem));
            p_rem = 32'(num % dv);
            nd = clip16(longint'(p_interval) - num / dv, sat);
            if (cnt >= ad) p_mode = MODE_DECEL;
            else if (nd <= p_min_delay) begin
                p_cruise = p_interval;
                nd = p_min_delay;
                p_rem = 32'd0;
                p_mode = MODE_RUN;
            end
        end else if (p_mode == MODE_RUN) begin
            nd = p_min_delay;
            if (longint'($signed(p_count)) >= ad) begin
                nd = p_cruise;
                p_mode = MODE_DECEL;
            end
        end else begin
            cnt = longint'($signed(p_count)) - 1;
            p_count = cnt[31:0];
            dv = -4 * cnt + 1;
            num = 2 * longint'(p_interval) + longint'($signed(p_rem));
            p_rem = 32'(num % dv);
            nd = clip16(longint'(p_interval) - num / dv, sat);
            if (cnt <= 0) begin
                p_mode = MODE_STOP;
                if (d != 0) begin
                    plan_move(gap_bits);
                    replanned = p_mode != MODE_STOP;
                end
            end
        end
        if (replanned) sat = 1'b0;
        else p_interval = nd;
        p_wait = p_interval != 16'd0 ? p_interval - 16'd1 : 16'd0;
        return sat;
    endfunction

    function automatic motion_rec_t predict_motion(input op_t op, input logic [31:0] val);
        motion_rec_t r;
        r = '0;
        if (op == OP_TICK) begin
            if (p_mode != MODE_STOP) begin
                if (p_wait > 16'd0) p_wait--;
                else begin
                    r.sat = take_step();
                    r.pulse = 1'b1;
                end
            end
        end else if (op == OP_TARGET) begin
            p_target = val;
            plan_move(p_target - p_pos);
        end else if (op == OP_SETPOS) begin
            p_pos = val;
            p_target = val;
            plan_move(32'd0);
        end
        r.dir = p_dir;
        r.enable = p_enabled;
        r.pos = p_pos;
        r.mode = p_mode;
        r.interval = p_interval;
        return r;
    endfunction

    task automatic send_item(input op_t op, input logic [31:0] val);
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, val, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_q.push_back(predict_motion(op, val));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_MIN_DELAY:  p_min_delay = val;
            REG_INIT_DELAY: p_init_delay = val;
            default:        p_threshold = val[7:0];
        endcase
    endtask

    task automatic run_ticks(input int n);
        repeat (n) send_item(OP_TICK, $urandom);
    endtask

    task automatic test_directed();
        send_item(OP_TICK, 32'hFFFF_FFFF);
        send_item(OP_NONE, 32'hFFFF_FFFF);
        send_item(OP_TARGET, 32'd3);
        send_item(OP_TARGET, 32'd20);
        run_ticks(6);
        send_item(OP_TARGET, 32'hFFFF_FFF0);
        run_ticks(6);
        send_item(OP_SETPOS, 32'h7FFF_FFFF);
        send_item(OP_SETPOS, 32'h8000_0000);
        send_item(OP_TARGET, 32'h7FFF_FFFF);
        send_item(OP_SETPOS, 32'd0);
    endtask

    task automatic test_one_step();
        write_reg(REG_THRESHOLD, 16'd0);
        write_reg(REG_MIN_DELAY, 16'd1);
        write_reg(REG_INIT_DELAY, 16'd3);
        send_item(OP_TARGET, 32'd1);
        run_ticks(100);
        send_item(OP_TARGET, 32'd0);
        run_ticks(100);
    endtask

    task automatic test_saturation();
        write_reg(REG_INIT_DELAY, 16'hFFFF);
        write_reg(REG_MIN_DELAY, 16'hFFFF);
        send_item(OP_TARGET, 32'd3);
        run_ticks(4);
        send_item(OP_SETPOS, 32'd0);
        write_reg(REG_MIN_DELAY, 16'd2);
        write_reg(REG_INIT_DELAY, 16'd40);
        write_reg(REG_THRESHOLD, 16'd255);
        send_item(OP_TARGET, 32'd300);
        send_item(OP_TARGET, 32'd255);
        send_item(OP_SETPOS, 32'd0);
    endtask

    task automatic test_random_moves(input int n_items);
        int sent;
        int k;
        sent = 0;
        while (sent < n_items) begin
            k = $urandom_range(99);
            if (k < 8) begin
                send_item(OP_TARGET, $urandom);
                sent++;
            end else if (k < 30) begin
                send_item(OP_TARGET, p_pos + $signed($urandom_range(60)) - 30);
                sent++;
            end else if (k < 33) begin
                send_item(op_t'($urandom_range(2, 3)), $urandom);
                sent++;
            end else begin
                k = $urandom_range(4, 20);
                run_ticks(k);
                sent += k;
            end
        end
        send_item(OP_SETPOS, $urandom);
    endtask

    initial begin
        p_min_delay = 16'd100; p_init_delay = 16'd2000; p_threshold = 8'd8;
        p_pos = 32'd0; p_target = 32'd0; p_dir = 1'b1; p_mode = MODE_STOP;
        p_count = 32'd0; p_interval = 16'd0; p_cruise = 16'd0; p_rem = 32'd0;
        p_wait = 16'd0; p_enabled = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        active = 1;
        test_directed();
        write_reg(REG_MIN_DELAY, 16'd3);
        write_reg(REG_INIT_DELAY, 16'd25);
        write_reg(REG_THRESHOLD, 16'd2);
        test_random_moves(220);
        test_one_step();
        test_saturation();
        write_reg(REG_MIN_DELAY, 16'd2);
        write_reg(REG_INIT_DELAY, 16'd12);
        write_reg(REG_THRESHOLD, 16'd1);
        idle_pct = 0;
        test_random_moves(150);
        idle_pct = 11;
        test_random_moves(250);
        drain_results();
        if (errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

    always @(posedge aclk) begin
        m_tready <= active ? ($urandom_range(99) >= idle_pct) : 1'b0;
    end

    always @(posedge aclk) begin
        motion_rec_t got, exp;
        if (m_tvalid && m_tready) begin
            got = m_tdata[53:0];
            if (expected_q.size() == 0) report_mismatch("unexpected beat", got, 0);
            else begin
                exp = expected_q.pop_front();
                if (got.pulse !== exp.pulse) report_mismatch("step_pulse", got.pulse, exp.pulse);
                if (got.dir !== exp.dir) report_mismatch("direction", got.dir, exp.dir);
                if (got.enable !== exp.enable)
                    report_mismatch("drive_enable", got.enable, exp.enable);
                if (got.pos !== exp.pos) report_mismatch("position_now", got.pos, exp.pos);
                if (got.mode !== exp.mode) report_mismatch("motion_state", got.mode, exp.mode);
                if (got.interval !== exp.interval)
                    report_mismatch("step_interval", got.interval, exp.interval);
                if (got.sat !== exp.sat)
                    report_mismatch("interval_saturated", got.sat, exp.sat);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !active) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("Some tests failed");
            $finish;
        end
    end
endmodule

@@ sim.f @@
hdl/srpg_pkg.sv
hdl/stepper_ramp_profile_generator.sv
bench/tb_stepper_ramp_profile_generator.sv
